FILE: src/pdeq_pkg.sv
`default_nettype none

package pdeq_pkg;

	// Store size and the index widths that follow from it. Null is the index DEPTH.
	localparam int DEPTH  = 256;
	localparam int IDX_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] NIL = IDX_W'(DEPTH);

	localparam int VAL_W = 64;
	localparam int LEN_W = 4;
	localparam int TOT_W = 9;
	localparam int ENT_W = VAL_W + LEN_W;

	localparam logic [LEN_W-1:0] MAX_BYTES = LEN_W'(8);

	localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_COUNT      = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [1:0]       priority_req;
		logic [VAL_W-1:0] value;
		logic [LEN_W-1:0] value_bytes;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [VAL_W-1:0] popped_value;
		logic [LEN_W-1:0] popped_bytes;
		logic [TOT_W-1:0] element_total;
	} rsp_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic step_a;
		logic step_b;
		logic out_direct;
		logic out_hold;
	} ctl_cmd_t;

endpackage

`default_nettype wire

FILE: src/priority_double_ended_queue_unit.sv
`default_nettype none

// Channel  Handshake                 Word
// cmd      cmd_valid / cmd_stall     cmd  (opcode, priority_req, value, value_bytes)
// rsp      rsp_valid / rsp_stall     rsp  (status, popped_value, popped_bytes, element_total)
//
// Each command word is worked in a first step, which reads the links of the chosen
// entry and writes a new entry, and a second step, which writes back the neighbor
// link and moves the list heads, as each link memory has one read and one write port.
// Reset takes effect at once: no clearing pass, a fill mark stands in for the
// initial free list. A stalled response holds in the output register while one
// more command word is taken and worked; its result then waits for the register.

// The block keeps one bounded double-ended queue and three priority stacks in a
// shared entry store. Entries are linked into a free list, the deque (doubly
// linked) or one of the stacks. Pushes with a nonzero priority go to that
// level's stack whichever end was asked for. Pops drain level 3, then 2, then 1,
// and only then take the requested end of the deque. Every command word gives
// exactly one response word.
//
// The controller runs the two work steps and the output handshake; the datapath
// holds the list heads, the entry memories and the output register.
module priority_double_ended_queue_unit
	import pdeq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_word_t cmd,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp
);

	ctl_cmd_t ctl;

	// Sequencer: accepts words, steps the datapath and loads the output.
	pdeq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl)
	);

	// Lists, memories and the response register.
	pdeq_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.item   (cmd),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

FILE: src/pdeq_ram.sv
`default_nettype none

// One write port and one read port, registered read data. A read and a write
// to the same address in one cycle return the old contents.
module pdeq_ram #(
	parameter int WIDTH = 8,
	parameter int WORDS = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(WORDS)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(WORDS)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: src/pdeq_ctrl.sv
`default_nettype none

module pdeq_ctrl
	import pdeq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output ctl_cmd_t  ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC_A,
		S_EXEC_B,
		S_WAIT
	} state_t;

	state_t state_q;
	logic   out_free;
	logic   ready;

	// The output register can take a result when empty or when its word leaves now.
	assign out_free = !rsp_valid || !rsp_stall;
	assign ready = (state_q == S_IDLE) ||
		(((state_q == S_EXEC_B) || (state_q == S_WAIT)) && out_free);
	assign cmd_stall = !ready;

	always_comb begin
		ctl.accept     = ready && cmd_valid;
		ctl.step_a     = (state_q == S_EXEC_A);
		ctl.step_b     = (state_q == S_EXEC_B);
		ctl.out_direct = (state_q == S_EXEC_B) && out_free;
		ctl.out_hold   = (state_q == S_WAIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp_valid <= 1'b0;
		end else begin
			if (ctl.out_direct || ctl.out_hold) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q) inside
				S_IDLE: begin
					if (ctl.accept) begin
						state_q <= S_EXEC_A;
					end
				end
				S_EXEC_A: begin
					state_q <= S_EXEC_B;
				end
				S_EXEC_B, S_WAIT: begin
					if (ctl.accept) begin
						state_q <= S_EXEC_A;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WAIT;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/pdeq_dpath.sv
`default_nettype none

module pdeq_dpath
	import pdeq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ctl_cmd_t  ctl,
	input  wire cmd_word_t item,
	output rsp_word_t      rsp
);

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_PUSH_STACK,
		ACT_PUSH_BACK,
		ACT_PUSH_FRONT,
		ACT_POP_STACK,
		ACT_POP_FRONT,
		ACT_POP_BACK
	} act_t;

	cmd_word_t item_q;

	// List heads, fill mark and count.
	logic [IDX_W-1:0] free_head_q;
	logic [IDX_W-1:0] fill_q;
	logic [IDX_W-1:0] front_q;
	logic [IDX_W-1:0] back_q;
	logic [IDX_W-1:0] top_q [3];
	logic [IDX_W-1:0] count_q;

	// Decisions made in the first step, used in the second.
	act_t             act_q;
	logic [IDX_W-1:0] node_q;
	logic [1:0]       lvl_q;
	logic [1:0]       status_q;

	rsp_word_t res_q;
	rsp_word_t out_q;

	// First step decode.
	act_t             act_a;
	logic [IDX_W-1:0] node_a;
	logic [1:0]       lvl_a;
	logic [1:0]       status_a;
	logic [LEN_W-1:0] len_clamp;
	logic [VAL_W-1:0] val_masked;
	logic [IDX_W-1:0] fwd_wd_a;
	logic [IDX_W-1:0] bwd_wd_a;

	// Second step.
	logic [IDX_W-1:0] count_next;
	rsp_word_t        res_b;

	// Memory ports.
	logic             pay_we;
	logic [ADDR_W-1:0] pay_wa;
	logic [ENT_W-1:0] pay_wd;
	logic [ENT_W-1:0] pay_rd;
	logic             fwd_we;
	logic [ADDR_W-1:0] fwd_wa;
	logic [IDX_W-1:0] fwd_wd;
	logic [IDX_W-1:0] fwd_rd;
	logic             bwd_we;
	logic [ADDR_W-1:0] bwd_wa;
	logic [IDX_W-1:0] bwd_wd;
	logic [IDX_W-1:0] bwd_rd;
	logic [ADDR_W-1:0] rd_addr;

	always_comb begin
		len_clamp = (item_q.value_bytes > MAX_BYTES) ? MAX_BYTES : item_q.value_bytes;
		for (int b = 0; b < VAL_W / 8; b++) begin
			val_masked[b*8 +: 8] = (LEN_W'(b) < len_clamp) ? item_q.value[b*8 +: 8] : 8'd0;
		end
	end

	always_comb begin
		act_a    = ACT_NONE;
		node_a   = free_head_q;
		lvl_a    = 2'd0;
		status_a = ST_OK;
		unique case (item_q.opcode) inside
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (count_q >= IDX_W'(DEPTH)) begin
					status_a = ST_FULL;
				end else if (item_q.priority_req != 2'd0) begin
					act_a = ACT_PUSH_STACK;
					lvl_a = item_q.priority_req - 2'd1;
				end else if (item_q.opcode == OP_PUSH_BACK) begin
					act_a = ACT_PUSH_BACK;
				end else begin
					act_a = ACT_PUSH_FRONT;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (top_q[2] != NIL) begin
					act_a  = ACT_POP_STACK;
					lvl_a  = 2'd2;
					node_a = top_q[2];
				end else if (top_q[1] != NIL) begin
					act_a  = ACT_POP_STACK;
					lvl_a  = 2'd1;
					node_a = top_q[1];
				end else if (top_q[0] != NIL) begin
					act_a  = ACT_POP_STACK;
					lvl_a  = 2'd0;
					node_a = top_q[0];
				end else if ((front_q == NIL) || (back_q == NIL)) begin
					status_a = ST_EMPTY;
				end else if (item_q.opcode == OP_POP_FRONT) begin
					act_a  = ACT_POP_FRONT;
					node_a = front_q;
				end else begin
					act_a  = ACT_POP_BACK;
					node_a = back_q;
				end
			end
			OP_COUNT: begin
				act_a = ACT_NONE;
			end
			default: begin
				act_a = ACT_NONE;
			end
		endcase
	end

	// Links of the entry touched in the first step. A popped entry is linked onto the
	// free list here; the read of its old forward link sees the value before.
	always_comb begin
		fwd_wd_a = NIL;
		bwd_wd_a = NIL;
		case (act_a) inside
			ACT_PUSH_STACK: fwd_wd_a = top_q[lvl_a];
			ACT_PUSH_BACK:  bwd_wd_a = back_q;
			ACT_PUSH_FRONT: fwd_wd_a = front_q;
			ACT_POP_STACK, ACT_POP_FRONT, ACT_POP_BACK: fwd_wd_a = free_head_q;
			default: fwd_wd_a = NIL;
		endcase
	end

	assign rd_addr = node_a[ADDR_W-1:0];

	always_comb begin
		pay_we = 1'b0;
		pay_wa = node_a[ADDR_W-1:0];
		pay_wd = {len_clamp, val_masked};
		fwd_we = 1'b0;
		fwd_wa = node_a[ADDR_W-1:0];
		fwd_wd = fwd_wd_a;
		bwd_we = 1'b0;
		bwd_wa = node_a[ADDR_W-1:0];
		bwd_wd = bwd_wd_a;
		if (ctl.step_a) begin
			pay_we = (act_a == ACT_PUSH_STACK) || (act_a == ACT_PUSH_BACK) ||
				(act_a == ACT_PUSH_FRONT);
			fwd_we = (act_a != ACT_NONE);
			bwd_we = pay_we;
		end else if (ctl.step_b) begin
			// Second step: the neighbor link of the deque end that moved.
			case (act_q)
				ACT_PUSH_BACK: begin
					fwd_we = (back_q != NIL);
					fwd_wa = back_q[ADDR_W-1:0];
					fwd_wd = node_q;
				end
				ACT_PUSH_FRONT: begin
					bwd_we = (front_q != NIL);
					bwd_wa = front_q[ADDR_W-1:0];
					bwd_wd = node_q;
				end
				ACT_POP_FRONT: begin
					bwd_we = (fwd_rd != NIL);
					bwd_wa = fwd_rd[ADDR_W-1:0];
					bwd_wd = NIL;
				end
				ACT_POP_BACK: begin
					fwd_we = (bwd_rd != NIL);
					fwd_wa = bwd_rd[ADDR_W-1:0];
					fwd_wd = NIL;
				end
				default: begin
					fwd_we = 1'b0;
				end
			endcase
		end
	end

	pdeq_ram #(.WIDTH(ENT_W), .WORDS(DEPTH)) u_pay_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_wa),
		.wdata (pay_wd),
		.raddr (rd_addr),
		.rdata (pay_rd)
	);

	pdeq_ram #(.WIDTH(IDX_W), .WORDS(DEPTH)) u_fwd_ram (
		.clk   (clk),
		.we    (fwd_we),
		.waddr (fwd_wa),
		.wdata (fwd_wd),
		.raddr (rd_addr),
		.rdata (fwd_rd)
	);

	pdeq_ram #(.WIDTH(IDX_W), .WORDS(DEPTH)) u_bwd_ram (
		.clk   (clk),
		.we    (bwd_we),
		.waddr (bwd_wa),
		.wdata (bwd_wd),
		.raddr (rd_addr),
		.rdata (bwd_rd)
	);

	always_comb begin
		count_next = count_q;
		case (act_q) inside
			ACT_PUSH_STACK, ACT_PUSH_BACK, ACT_PUSH_FRONT: count_next = count_q + 1'b1;
			ACT_POP_STACK, ACT_POP_FRONT, ACT_POP_BACK: count_next = count_q - 1'b1;
			default: count_next = count_q;
		endcase
		res_b.status        = status_q;
		res_b.popped_value  = '0;
		res_b.popped_bytes  = '0;
		res_b.element_total = TOT_W'(count_next);
		if ((act_q == ACT_POP_STACK) || (act_q == ACT_POP_FRONT) || (act_q == ACT_POP_BACK)) begin
			res_b.popped_value = pay_rd[VAL_W-1:0];
			res_b.popped_bytes = pay_rd[ENT_W-1:VAL_W];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			item_q <= item;
		end
		if (ctl.step_a) begin
			act_q    <= act_a;
			node_q   <= node_a;
			lvl_q    <= lvl_a;
			status_q <= status_a;
		end
		if (ctl.step_b) begin
			res_q <= res_b;
		end
		if (ctl.out_direct) begin
			out_q <= res_b;
		end else if (ctl.out_hold) begin
			out_q <= res_q;
		end
	end

	// List heads. Entries at and above the fill mark were never used, so the
	// free list continues through them in index order without a stored link.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			fill_q      <= '0;
			front_q     <= NIL;
			back_q      <= NIL;
			top_q[0]    <= NIL;
			top_q[1]    <= NIL;
			top_q[2]    <= NIL;
			count_q     <= '0;
		end else if (ctl.step_b) begin
			count_q <= count_next;
			case (act_q) inside
				ACT_PUSH_STACK, ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
					if (node_q == fill_q) begin
						free_head_q <= fill_q + 1'b1;
						fill_q      <= fill_q + 1'b1;
					end else begin
						free_head_q <= fwd_rd;
					end
				end
				ACT_POP_STACK, ACT_POP_FRONT, ACT_POP_BACK: begin
					free_head_q <= node_q;
				end
				default: begin
					free_head_q <= free_head_q;
				end
			endcase
			case (act_q)
				ACT_PUSH_STACK: begin
					top_q[lvl_q] <= node_q;
				end
				ACT_PUSH_BACK: begin
					if (back_q == NIL) begin
						front_q <= node_q;
					end
					back_q <= node_q;
				end
				ACT_PUSH_FRONT: begin
					if (front_q == NIL) begin
						back_q <= node_q;
					end
					front_q <= node_q;
				end
				ACT_POP_STACK: begin
					top_q[lvl_q] <= fwd_rd;
				end
				ACT_POP_FRONT: begin
					front_q <= fwd_rd;
					if (fwd_rd == NIL) begin
						back_q <= NIL;
					end
				end
				ACT_POP_BACK: begin
					back_q <= bwd_rd;
					if (bwd_rd == NIL) begin
						front_q <= NIL;
					end
				end
				default: begin
					front_q <= front_q;
				end
			endcase
		end
	end

	assign rsp = out_q;

endmodule

`default_nettype wire

FILE: src/pdeq_checker.sv
`default_nettype none

module pdeq_props
	import pdeq_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      cmd_valid,
	input wire logic      cmd_stall,
	input wire logic      rsp_valid,
	input wire logic      rsp_stall,
	input wire rsp_word_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response word dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("stalled response word changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while the previous one is still at work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_EMPTY ||
			rsp.status == ST_FULL))
		else $error("unknown status code");

	a_quiet_failure: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.popped_value == '0 &&
			rsp.popped_bytes == '0)
		else $error("failed command returned a payload");

endmodule

bind priority_double_ended_queue_unit pdeq_props u_pdeq_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
